// File: src/bwts_pkg.sv
// Shared types and constants for the bilinear wrap texture sampler.
// Holds the word layouts, register indexes, item kinds and sequencer states.
// No dependencies.
package bwts_pkg;

	// Fixed field geometry
	localparam int COORD_BITS  = 16;
	localparam int WEIGHT_BITS = 8;
	localparam int SIZE_W      = 13;               // size register width
	localparam int POS_W       = 12;               // texel column/row, 0..4095
	localparam int IDX_W       = 2 * POS_W;        // linear texel index before wrap
	localparam int WX_W        = WEIGHT_BITS + 1;  // one axis weight, 0..2^WEIGHT_BITS
	localparam int WT_W        = 2 * WEIGHT_BITS + 1;
	localparam int OUT_W       = 24;
	localparam int ACC_W       = OUT_W + 1;
	localparam int MUL_A_W     = WT_W;
	localparam int MUL_B_W     = SIZE_W;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	// Register indexes
	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	// Item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] texel_address;
		logic [31:0] texel_rgba;
		logic [15:0] coord_u;
		logic [15:0] coord_v;
	} sample_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] red_out;
		logic [OUT_W-1:0] green_out;
		logic [OUT_W-1:0] blue_out;
		logic [OUT_W-1:0] alpha_out;
	} sample_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_U,
		ST_MUL_V,
		ST_INDEX,
		ST_REDUCE,
		ST_WRITE,
		ST_READ,
		ST_WEIGHT,
		ST_BLEND,
		ST_DONE
	} seq_state_t;

endpackage

// File: src/bilinear_wrap_texture_sampler_unit.sv
// Top level of the bilinear wrap texture sampler: texel memory, size registers,
// and a sequencer around one shared 17x13 multiplier.
// Depends on bwts_pkg.
//
// A sample word passes MUL_U and MUL_V, then per texel INDEX, R wrap steps, READ, WEIGHT,
// four BLEND steps and finally DONE, which loads the output register. R is 0 for a
// power-of-two TEXEL_DEPTH and IDX_W - clog2(TEXEL_DEPTH) + 1 otherwise (index wrap by
// compare-subtract, one step a cycle). Each of the four texels costs index, read, weight
// and four channel multiplies on the shared multiplier; new items are taken only in IDLE.
// Reset (arst_n low, asynchronous) restores both sizes to 256 and empties the output
// register; the texel memory is not cleared and no clearing pass runs.
module bilinear_wrap_texture_sampler_unit #(
	parameter int TEXEL_DEPTH = 65536
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  bwts_pkg::sample_in_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bwts_pkg::sample_out_t   out_data,
	input  logic                    cfg_wr_en,
	input  logic                    cfg_index,
	input  logic [bwts_pkg::SIZE_W-1:0] cfg_data
);
	import bwts_pkg::*;

	localparam int  ADDR_W     = $clog2(TEXEL_DEPTH);
	localparam bit  DEPTH_POW2 = (TEXEL_DEPTH & (TEXEL_DEPTH - 1)) == 0;
	// Compare-subtract steps that bring any 24-bit index below the depth
	localparam int  RED_STEPS  = DEPTH_POW2 ? 0 : IDX_W - ADDR_W + 1;
	localparam int  RED_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam logic [RED_W-1:0] RED_LAST = RED_W'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(TEXEL_DEPTH);
	localparam logic [WX_W-1:0]  W_ONE     = WX_W'(1 << WEIGHT_BITS);

	// Size registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [SIZE_W-1:0] cfg_clamped;

	// Sequencer and datapath registers
	seq_state_t         state_q, state_d;
	logic               is_write_q;
	logic [31:0]        rgba_q;
	logic [COORD_BITS-1:0] u_q, v_q;
	logic [POS_W-1:0]   x0_q, x1_q, y0_q, y1_q;
	logic [WEIGHT_BITS-1:0] fx_q, fy_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RED_W-1:0]   red_q;
	logic [1:0]         k_q, ch_q;
	logic [WT_W-1:0]    wt_q;
	logic [ACC_W-1:0]   acc_q [4];

	// Output register
	logic               out_valid_q;
	sample_out_t        out_data_q;

	// Texel memory
	logic [31:0]        mem [TEXEL_DEPTH];
	logic [31:0]        mem_rd_q;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_addr;

	// Shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	// Misc combinational
	logic               accept;
	logic               out_load;
	logic [POS_W-1:0]   row_k, col_k;
	logic [WX_W-1:0]    wx_k, wy_k;
	logic [SIZE_W-1:0]  pos_next;
	logic [POS_W-1:0]   pos_lo;
	logic [IDX_W-1:0]   red_cmp;
	logic [7:0]         chan_byte;

	assign accept   = in_valid && in_ready;
	assign mul_p    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign mem_addr = idx_q[ADDR_W-1:0];

	// Neighbor selection: bit 0 of the texel count picks the next column,
	// bit 1 the next row; weights follow the same pattern.
	assign col_k = k_q[0] ? x1_q : x0_q;
	assign row_k = k_q[1] ? y1_q : y0_q;
	assign wx_k  = k_q[0] ? WX_W'(fx_q) : W_ONE - WX_W'(fx_q);
	assign wy_k  = k_q[1] ? WX_W'(fy_q) : W_ONE - WX_W'(fy_q);

	// Integer part of the scaled coordinate, and its successor with wrap
	assign pos_lo    = mul_p[COORD_BITS +: POS_W];
	assign red_cmp   = DEPTH_IDX << red_q;
	assign chan_byte = mem_rd_q[{ch_q, 3'b000} +: 8];

	// Clamp a size write into 1..4096
	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = SIZE_MIN;
		end else if (cfg_data > SIZE_MAX) begin
			cfg_clamped = SIZE_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.kind == KIND_SAMPLE) begin
						state_d = ST_MUL_U;
					end else begin
						state_d = (RED_STEPS > 0) ? ST_REDUCE : ST_WRITE;
					end
				end
			end
			ST_MUL_U: state_d = ST_MUL_V;
			ST_MUL_V: state_d = ST_INDEX;
			ST_INDEX: state_d = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
			ST_REDUCE: begin
				if (red_q == '0) begin
					state_d = is_write_q ? ST_WRITE : ST_READ;
				end
			end
			ST_WRITE:  state_d = ST_IDLE;
			ST_READ:   state_d = ST_WEIGHT;
			ST_WEIGHT: state_d = ST_BLEND;
			ST_BLEND: begin
				if (ch_q == 2'd3) begin
					state_d = (k_q == 2'd3) ? ST_DONE : ST_INDEX;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, memory strobes, multiplier operands
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_MUL_U: begin
				mul_a = MUL_A_W'(u_q);
				mul_b = width_q;
			end
			ST_MUL_V: begin
				mul_a = MUL_A_W'(v_q);
				mul_b = height_q;
			end
			ST_INDEX: begin
				mul_a = MUL_A_W'(row_k);
				mul_b = width_q;
			end
			ST_WRITE: mem_we = 1'b1;
			ST_READ:  mem_re = 1'b1;
			ST_WEIGHT: begin
				mul_a = MUL_A_W'(wx_k);
				mul_b = MUL_B_W'(wy_k);
			end
			ST_BLEND: begin
				mul_a = wt_q;
				mul_b = MUL_B_W'(chan_byte);
			end
			ST_DONE:  out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign pos_next = SIZE_W'(pos_lo) + SIZE_W'(1);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= SIZE_RESET;
			height_q    <= SIZE_RESET;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			ch_q        <= '0;
			red_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TEX_WIDTH:  width_q  <= cfg_clamped;
					REG_TEX_HEIGHT: height_q <= cfg_clamped;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Texel and channel counters
			if (accept) begin
				k_q  <= '0;
				ch_q <= '0;
			end else if (state_q == ST_BLEND) begin
				ch_q <= ch_q + 2'd1;
				if (ch_q == 2'd3) begin
					k_q <= k_q + 2'd1;
				end
			end
			// Index wrap step counter, counts down
			if (accept || state_q == ST_INDEX) begin
				red_q <= RED_LAST;
			end else if (state_q == ST_REDUCE) begin
				red_q <= red_q - RED_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_write_q <= (in_data.kind == KIND_WRITE);
			rgba_q     <= in_data.texel_rgba;
			u_q        <= in_data.coord_u;
			v_q        <= in_data.coord_v;
			idx_q      <= IDX_W'(in_data.texel_address);
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= '0;
			end
		end
		case (state_q)
			ST_MUL_U: begin
				x0_q <= pos_lo;
				x1_q <= (pos_next >= width_q) ? '0 : pos_next[POS_W-1:0];
				fx_q <= mul_p[COORD_BITS-WEIGHT_BITS +: WEIGHT_BITS];
			end
			ST_MUL_V: begin
				y0_q <= pos_lo;
				y1_q <= (pos_next >= height_q) ? '0 : pos_next[POS_W-1:0];
				fy_q <= mul_p[COORD_BITS-WEIGHT_BITS +: WEIGHT_BITS];
			end
			ST_INDEX:  idx_q <= mul_p[IDX_W-1:0] + IDX_W'(col_k);
			ST_REDUCE: begin
				if (idx_q >= red_cmp) begin
					idx_q <= idx_q - red_cmp;
				end
			end
			ST_WEIGHT: wt_q <= mul_p[WT_W-1:0];
			// Weights carry 2*WEIGHT_BITS = 16 fraction bits, already the output scale
			ST_BLEND:  acc_q[ch_q] <= acc_q[ch_q] + ACC_W'(mul_p);
			default: ;
		endcase
		if (out_load) begin
			out_data_q.red_out   <= acc_q[0][OUT_W-1:0];
			out_data_q.green_out <= acc_q[1][OUT_W-1:0];
			out_data_q.blue_out  <= acc_q[2][OUT_W-1:0];
			out_data_q.alpha_out <= acc_q[3][OUT_W-1:0];
		end
	end

	// Texel memory, single port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= rgba_q;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: src/bwts_checker.sv
// Port-level checker for the bilinear wrap texture sampler, and its bind.
// Depends on bwts_pkg and bilinear_wrap_texture_sampler_unit.
module bwts_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input bwts_pkg::sample_in_t  in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input bwts_pkg::sample_out_t out_data
);
	import bwts_pkg::*;

	localparam logic [OUT_W-1:0] CHAN_MAX = OUT_W'(255 << 16);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed or dropped while stalled");

	// A sample keeps the block busy on the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind == KIND_SAMPLE |=> !in_ready)
		else $error("sample accepted back to back");

	// A new result appears only while an item is being worked
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a sample in flight");

	// Blended channels never exceed full scale
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.red_out <= CHAN_MAX && out_data.green_out <= CHAN_MAX
			&& out_data.blue_out <= CHAN_MAX && out_data.alpha_out <= CHAN_MAX)
		else $error("filtered channel above full scale");

endmodule

bind bilinear_wrap_texture_sampler_unit bwts_checker u_bwts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
